// ===== rtl/core/rcir_pkg.sv =====
// rcir_pkg: shared types and constants for the raster counter / irq register unit
// no dependencies; used by the channel interfaces, rcir_core and the top level

package rcir_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned OFFSET_W  = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned LINE_W    = 9;
  localparam int unsigned PIXEL_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 2'd2;

  // configuration reset values
  localparam logic [STEP_W-1:0] PIXEL_STEP_RST  = 6'd6;
  localparam logic [LINE_W-1:0] LINE_LENGTH_RST = 9'd403;
  localparam logic [LINE_W-1:0] FRAME_LINES_RST = 9'd284;

  // register map offsets
  localparam logic [OFFSET_W-1:0] OFF_CR1    = 6'h11;
  localparam logic [OFFSET_W-1:0] OFF_RASTER = 6'h12;
  localparam logic [OFFSET_W-1:0] OFF_MP     = 6'h18;
  localparam logic [OFFSET_W-1:0] OFF_IR     = 6'h19;
  localparam logic [OFFSET_W-1:0] OFF_IE     = 6'h1A;
  localparam logic [OFFSET_W-1:0] OFF_BG0    = 6'h21;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [OFFSET_W-1:0] reg_offset;
    logic [BYTE_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              irq_raised;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/rcir_if.sv =====
// rcir_if: valid/ready channel interfaces for items, results and config writes
// depends on rcir_pkg for field widths

interface rcir_in_if;
  logic                              valid;
  logic                              ready;
  logic [rcir_pkg::OP_W-1:0]         op;
  logic [rcir_pkg::OFFSET_W-1:0]     reg_offset;
  logic [rcir_pkg::BYTE_W-1:0]       write_data;

  modport source (output valid, output op, output reg_offset, output write_data, input ready);
  modport sink   (input valid, input op, input reg_offset, input write_data, output ready);
endinterface

interface rcir_out_if;
  logic                              valid;
  logic                              ready;
  logic [rcir_pkg::BYTE_W-1:0]       read_data;
  logic                              irq_raised;

  modport source (output valid, output read_data, output irq_raised, input ready);
  modport sink   (input valid, input read_data, input irq_raised, output ready);
endinterface

interface rcir_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcir_pkg::CFG_IDX_W-1:0]    index;
  logic [rcir_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/raster_counter_irq_regs_unit.sv =====
// raster_counter_irq_regs_unit: top level with input beat register, rcir_core and
// result register; depends on rcir_pkg, rcir_if and rcir_core
// an item is held in the input beat register, then its result in the result register
// throughput: one item per cycle unless a held result stalls; the input register feeds
// the core logic, whose result lands in the output register, so both advance together
// reset: synchronous active-low; config returns to step 6, length 403, lines 284

module raster_counter_irq_regs_unit (
  input  logic        clk,
  input  logic        rst_n,
  rcir_in_if.sink     in_bus,
  rcir_out_if.source  out_bus,
  rcir_cfg_if.sink    cfg_bus
);

  logic              item_vld_r;
  rcir_pkg::item_t   item_r;
  logic              res_vld_r;
  rcir_pkg::result_t res_r;
  rcir_pkg::result_t res_nxt;
  rcir_pkg::cfg_wr_t cfg_wr;
  logic              advance;
  logic              in_fire;

  // item moves into the result register when that slot is free or draining
  assign advance        = item_vld_r && (!res_vld_r || out_bus.ready);
  assign in_bus.ready   = !item_vld_r || advance;
  assign in_fire        = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready  = 1'b1;
  assign cfg_wr.en      = cfg_bus.valid;
  assign cfg_wr.index   = cfg_bus.index;
  assign cfg_wr.data    = cfg_bus.data;

  rcir_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item_r),
    .commit (advance),
    .cfg_wr (cfg_wr),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op         <= in_bus.op;
      item_r.reg_offset <= in_bus.reg_offset;
      item_r.write_data <= in_bus.write_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid      = res_vld_r;
  assign out_bus.read_data  = res_r.read_data;
  assign out_bus.irq_raised = res_r.irq_raised;

endmodule

// ===== rtl/core/rcir_core.sv =====
// rcir_core: raster counters, register file and config registers; computes one result
// per item combinationally and commits state when the item advances; uses rcir_pkg

module rcir_core (
  input  logic              clk,
  input  logic              rst_n,
  input  rcir_pkg::item_t   item,
  input  logic              commit,
  input  rcir_pkg::cfg_wr_t cfg_wr,
  output rcir_pkg::result_t result
);

  logic [rcir_pkg::STEP_W-1:0]  pixel_step_r;
  logic [rcir_pkg::LINE_W-1:0]  line_length_r;
  logic [rcir_pkg::LINE_W-1:0]  frame_lines_r;

  logic [rcir_pkg::PIXEL_W-1:0] pixel_count_r, pixel_count_nxt;
  logic [rcir_pkg::LINE_W-1:0]  raster_line_r, raster_line_nxt;
  logic [rcir_pkg::LINE_W-1:0]  raster_compare_r, raster_compare_nxt;
  logic [rcir_pkg::BYTE_W-1:0]  memory_pointers_r, memory_pointers_nxt;
  logic [rcir_pkg::BYTE_W-1:0]  irq_latch_r, irq_latch_nxt;
  logic [rcir_pkg::BYTE_W-1:0]  irq_enable_r, irq_enable_nxt;
  logic [rcir_pkg::BYTE_W-1:0]  background_colour_r, background_colour_nxt;

  logic [rcir_pkg::PIXEL_W:0]   pixel_sum;
  logic [rcir_pkg::PIXEL_W:0]   pixel_wrap;
  logic [rcir_pkg::LINE_W:0]    line_inc;

  assign pixel_sum  = {1'b0, pixel_count_r} + {5'b0, pixel_step_r};
  assign pixel_wrap = pixel_sum - {2'b0, line_length_r};
  assign line_inc   = {1'b0, raster_line_r} + 10'd1;

  always_comb begin
    pixel_count_nxt       = pixel_count_r;
    raster_line_nxt       = raster_line_r;
    raster_compare_nxt    = raster_compare_r;
    memory_pointers_nxt   = memory_pointers_r;
    irq_latch_nxt         = irq_latch_r;
    irq_enable_nxt        = irq_enable_r;
    background_colour_nxt = background_colour_r;
    result                = '0;

    case (rcir_pkg::op_t'(item.op))
      rcir_pkg::OP_TICK: begin
        if (pixel_sum >= {2'b0, line_length_r}) begin
          pixel_count_nxt = pixel_wrap[rcir_pkg::PIXEL_W-1:0];
          // line wraps to zero at the frame end
          if (line_inc >= {1'b0, frame_lines_r}) begin
            raster_line_nxt = '0;
          end else begin
            raster_line_nxt = line_inc[rcir_pkg::LINE_W-1:0];
          end
          if (irq_enable_r[0] && (raster_line_nxt == raster_compare_r)) begin
            irq_latch_nxt     = irq_latch_r | 8'h01;
            result.irq_raised = 1'b1;
          end
        end else begin
          pixel_count_nxt = pixel_sum[rcir_pkg::PIXEL_W-1:0];
        end
      end
      rcir_pkg::OP_READ: begin
        case (item.reg_offset)
          rcir_pkg::OFF_CR1:    result.read_data = {raster_line_r[8], 7'b0};
          rcir_pkg::OFF_RASTER: result.read_data = raster_line_r[7:0];
          rcir_pkg::OFF_MP:     result.read_data = memory_pointers_r;
          rcir_pkg::OFF_IR:     result.read_data = {4'b0, irq_latch_r[3:0]};
          rcir_pkg::OFF_IE:     result.read_data = {4'b0, irq_enable_r[3:0]};
          rcir_pkg::OFF_BG0:    result.read_data = background_colour_r;
          default:              result.read_data = '0;
        endcase
      end
      rcir_pkg::OP_WRITE: begin
        case (item.reg_offset)
          rcir_pkg::OFF_CR1:    raster_compare_nxt = {item.write_data[7], raster_compare_r[7:0]};
          rcir_pkg::OFF_RASTER: raster_compare_nxt = {raster_compare_r[8], item.write_data};
          rcir_pkg::OFF_MP:     memory_pointers_nxt   = item.write_data;
          rcir_pkg::OFF_IR:     irq_latch_nxt         = item.write_data;
          rcir_pkg::OFF_IE:     irq_enable_nxt        = item.write_data;
          rcir_pkg::OFF_BG0:    background_colour_nxt = item.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r       <= '0;
      raster_line_r       <= '0;
      raster_compare_r    <= '0;
      memory_pointers_r   <= '0;
      irq_latch_r         <= '0;
      irq_enable_r        <= '0;
      background_colour_r <= '0;
    end else if (commit) begin
      pixel_count_r       <= pixel_count_nxt;
      raster_line_r       <= raster_line_nxt;
      raster_compare_r    <= raster_compare_nxt;
      memory_pointers_r   <= memory_pointers_nxt;
      irq_latch_r         <= irq_latch_nxt;
      irq_enable_r        <= irq_enable_nxt;
      background_colour_r <= background_colour_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_step_r  <= rcir_pkg::PIXEL_STEP_RST;
      line_length_r <= rcir_pkg::LINE_LENGTH_RST;
      frame_lines_r <= rcir_pkg::FRAME_LINES_RST;
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        rcir_pkg::CFG_PIXEL_STEP:  pixel_step_r  <= cfg_wr.data[rcir_pkg::STEP_W-1:0];
        rcir_pkg::CFG_LINE_LENGTH: line_length_r <= cfg_wr.data;
        rcir_pkg::CFG_FRAME_LINES: frame_lines_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/raster_counter_irq_regs_unit_checker.sv =====
// raster_counter_irq_regs_unit_checker: watches the item, result and config channels,
// keeps its own raster and register state, predicts every result and compares in order
// depends on rcir_pkg and the channel interfaces of rcir_if

module raster_counter_irq_regs_unit_checker (
  input  logic  clk,
  input  logic  rst_n,
  rcir_in_if    in_mon,
  rcir_out_if   out_mon,
  rcir_cfg_if   cfg_mon,
  output int    fail_count,
  output int    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // timing settings
  logic [rcir_pkg::STEP_W-1:0]  step_px;
  logic [rcir_pkg::LINE_W-1:0]  line_len;
  logic [rcir_pkg::LINE_W-1:0]  frame_len;

  // raster and register state
  logic [rcir_pkg::PIXEL_W-1:0] pixel_pos;
  logic [rcir_pkg::LINE_W-1:0]  raster_now;
  logic [rcir_pkg::LINE_W-1:0]  raster_cmp;
  logic [rcir_pkg::BYTE_W-1:0]  mem_ptrs;
  logic [rcir_pkg::BYTE_W-1:0]  latch_bits;
  logic [rcir_pkg::BYTE_W-1:0]  enable_bits;
  logic [rcir_pkg::BYTE_W-1:0]  bg_colour;

  rcir_pkg::result_t  raster_results_due [$];
  int                 failures = 0;

  task automatic flag_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endtask

  function automatic rcir_pkg::result_t predict_access(input rcir_pkg::item_t acc);
    rcir_pkg::result_t res;
    int unsigned       pos;
    int unsigned       nxt;
    res = '0;
    case (acc.op)
      rcir_pkg::OP_TICK: begin
        pos = 32'(pixel_pos) + 32'(step_px);
        // wrap test runs even with a zero step
        if (pos >= 32'(line_len)) begin
          pos = pos - 32'(line_len);
          nxt = 32'(raster_now) + 32'd1;
          if (nxt >= 32'(frame_len)) nxt = 0;
          raster_now = nxt[rcir_pkg::LINE_W-1:0];
          if (enable_bits[0] && raster_now == raster_cmp) begin
            latch_bits[0] = 1'b1;
            res.irq_raised = 1'b1;
          end
        end
        pixel_pos = pos[rcir_pkg::PIXEL_W-1:0];
      end
      rcir_pkg::OP_READ: begin
        case (acc.reg_offset)
          rcir_pkg::OFF_CR1:    res.read_data = {raster_now[rcir_pkg::LINE_W-1], 7'b0};
          rcir_pkg::OFF_RASTER: res.read_data = raster_now[7:0];
          rcir_pkg::OFF_MP:     res.read_data = mem_ptrs;
          rcir_pkg::OFF_IR:     res.read_data = {4'b0, latch_bits[3:0]};
          rcir_pkg::OFF_IE:     res.read_data = {4'b0, enable_bits[3:0]};
          rcir_pkg::OFF_BG0:    res.read_data = bg_colour;
          default:              res.read_data = '0;
        endcase
      end
      rcir_pkg::OP_WRITE: begin
        case (acc.reg_offset)
          rcir_pkg::OFF_CR1:    raster_cmp[rcir_pkg::LINE_W-1] = acc.write_data[7];
          rcir_pkg::OFF_RASTER: raster_cmp[7:0] = acc.write_data;
          rcir_pkg::OFF_MP:     mem_ptrs = acc.write_data;
          rcir_pkg::OFF_IR:     latch_bits = acc.write_data;
          rcir_pkg::OFF_IE:     enable_bits = acc.write_data;
          rcir_pkg::OFF_BG0:    bg_colour = acc.write_data;
          default:              ;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rcir_pkg::result_t want;
    rcir_pkg::item_t   acc;
    if (!rst_n) begin
      step_px     = rcir_pkg::PIXEL_STEP_RST;
      line_len    = rcir_pkg::LINE_LENGTH_RST;
      frame_len   = rcir_pkg::FRAME_LINES_RST;
      pixel_pos   = '0;
      raster_now  = '0;
      raster_cmp  = '0;
      mem_ptrs    = '0;
      latch_bits  = '0;
      enable_bits = '0;
      bg_colour   = '0;
      raster_results_due.delete();
    end else begin
      // results first: a result never belongs to an item accepted on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (raster_results_due.size() == 0) begin
          flag_failure($sformatf("result beat with nothing pending: read_data %02h irq %0b",
                                 out_mon.read_data, out_mon.irq_raised));
        end else begin
          want = raster_results_due.pop_front();
          if (out_mon.read_data !== want.read_data || out_mon.irq_raised !== want.irq_raised)
            flag_failure($sformatf("mismatch: expected read_data %02h irq %0b, got %02h irq %0b",
                                   want.read_data, want.irq_raised,
                                   out_mon.read_data, out_mon.irq_raised));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          rcir_pkg::CFG_PIXEL_STEP:  step_px = cfg_mon.data[rcir_pkg::STEP_W-1:0];
          rcir_pkg::CFG_LINE_LENGTH: line_len = cfg_mon.data;
          rcir_pkg::CFG_FRAME_LINES: frame_len = cfg_mon.data;
          default:                   ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        acc = {in_mon.op, in_mon.reg_offset, in_mon.write_data};
        raster_results_due.push_back(predict_access(acc));
      end
    end
    fail_count  <= failures;
    results_due <= raster_results_due.size();
  end

endmodule

// ===== dv/raster_counter_irq_regs_unit_test.sv =====
// raster_counter_irq_regs_unit_test: clock, reset, access stimulus, timing settings and
// result back-pressure for raster_counter_irq_regs_unit; verdict from the checker's count
// depends on rcir_pkg, rcir_if, the block and raster_counter_irq_regs_unit_checker

module raster_counter_irq_regs_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rcir_pkg::OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [rcir_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [rcir_pkg::OFFSET_W-1:0]  OFF_NONE   = 6'h3F;
  localparam logic [rcir_pkg::OFFSET_W-1:0]  OFF_ZERO   = 6'h00;
  localparam int TIMINGS     = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   items_in = 0;
  int   irqs_seen = 0;

  rcir_in_if  in_bus ();
  rcir_out_if out_bus ();
  rcir_cfg_if cfg_bus ();

  raster_counter_irq_regs_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  raster_counter_irq_regs_unit_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) items_in <= items_in + 1;
    if (out_bus.valid && out_bus.ready && out_bus.irq_raised) irqs_seen <= irqs_seen + 1;
  end

  function automatic logic [rcir_pkg::OFFSET_W-1:0] map_offset(input int unsigned k);
    case (k)
      0:       return rcir_pkg::OFF_CR1;
      1:       return rcir_pkg::OFF_RASTER;
      2:       return rcir_pkg::OFF_MP;
      3:       return rcir_pkg::OFF_IR;
      4:       return rcir_pkg::OFF_IE;
      default: return rcir_pkg::OFF_BG0;
    endcase
  endfunction

  // mostly ticks and map accesses; compare writes aim at reachable lines when frames > 1
  function automatic rcir_pkg::item_t random_access(input int unsigned frames,
                                                    input int unsigned tick_pct);
    rcir_pkg::item_t                 acc;
    int unsigned                     pick;
    int unsigned                     rest;
    logic [rcir_pkg::LINE_W-1:0]     target;
    acc.op         = rcir_pkg::OP_TICK;
    acc.reg_offset = 6'($urandom_range(0, 63));
    acc.write_data = 8'($urandom_range(0, 255));
    pick   = $urandom_range(0, 99);
    rest   = 100 - tick_pct;
    target = (frames > 1) ? 9'($urandom_range(0, frames - 1)) : 9'($urandom_range(0, 3));
    if (pick < tick_pct) begin
      acc.op = rcir_pkg::OP_TICK;
    end else if (pick < tick_pct + rest * 4 / 10) begin
      acc.op = rcir_pkg::OP_READ;
      if ($urandom_range(0, 4) != 0) acc.reg_offset = map_offset($urandom_range(0, 5));
    end else if (pick < tick_pct + rest * 9 / 10) begin
      acc.op = rcir_pkg::OP_WRITE;
      if ($urandom_range(0, 4) != 0) begin
        acc.reg_offset = map_offset($urandom_range(0, 5));
        case (acc.reg_offset)
          rcir_pkg::OFF_CR1:    acc.write_data[7] = target[rcir_pkg::LINE_W-1];
          rcir_pkg::OFF_RASTER: acc.write_data = target[7:0];
          rcir_pkg::OFF_IE:     acc.write_data[0] = ($urandom_range(0, 3) != 0);
          default:              ;
        endcase
      end
    end else begin
      acc.op = OP_UNUSED;
    end
    return acc;
  endfunction

  task automatic send_item(input rcir_pkg::item_t acc);
    in_bus.valid      <= 1'b1;
    in_bus.op         <= acc.op;
    in_bus.reg_offset <= acc.reg_offset;
    in_bus.write_data <= acc.write_data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rcir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcir_pkg::CFG_DAT_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [rcir_pkg::CFG_DAT_W-1:0] px_step,
                               input logic [rcir_pkg::CFG_DAT_W-1:0] len,
                               input logic [rcir_pkg::CFG_DAT_W-1:0] frames,
                               input bit poke_unused);
    write_reg(rcir_pkg::CFG_PIXEL_STEP, px_step);
    write_reg(rcir_pkg::CFG_LINE_LENGTH, len);
    write_reg(rcir_pkg::CFG_FRAME_LINES, frames);
    if (poke_unused) write_reg(CFG_UNUSED, '1);
    cfg_bus.valid <= 1'b0;
  endtask

  // quiet the input and wait until every predicted result has come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int unsigned frames,
                            input int unsigned tick_pct);
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      end
      send_item(random_access(frames, tick_pct));
      burst--;
    end
  endtask

  // result side: own stall pattern plus long hold-offs while items keep coming
  initial begin : result_sink
    int unsigned run;
    int          next_hold;
    next_hold = 150;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (items_in >= next_hold) begin
        next_hold = next_hold + 550;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      out_bus.ready <= 1'b1;
      repeat (run) @(posedge clk);
      run = $urandom_range(0, 4);
      if (run > 0) begin
        out_bus.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stall_watch
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [rcir_pkg::CFG_DAT_W-1:0] px;
    logic [rcir_pkg::CFG_DAT_W-1:0] len;
    logic [rcir_pkg::CFG_DAT_W-1:0] frames;
    int                             count;
    int unsigned                    tick_pct;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.op         <= rcir_pkg::OP_TICK;
    in_bus.reg_offset <= '0;
    in_bus.write_data <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= rcir_pkg::CFG_PIXEL_STEP;
    cfg_bus.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register map walk at reset timing
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_CR1, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_RASTER, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_MP, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_MP, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_BG0, 8'h5A});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_BG0, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_IE, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_IE, 8'h00});
    // latch takes the byte as written, ones do not clear
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_IR, 8'hF0});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_IR, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_CR1, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_RASTER, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_CR1, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, OFF_NONE, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, OFF_NONE, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, OFF_ZERO, 8'h00});
    send_item(rcir_pkg::item_t'{OP_UNUSED, rcir_pkg::OFF_IR, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_CR1, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_TICK, OFF_NONE, 8'hFF});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_TICK, OFF_ZERO, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_TICK, rcir_pkg::OFF_IR, 8'hAA});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_WRITE, rcir_pkg::OFF_IR, 8'h00});
    send_item(rcir_pkg::item_t'{rcir_pkg::OP_READ, rcir_pkg::OFF_IR, 8'h00});
    drain();

    run_random(80, 32'(rcir_pkg::FRAME_LINES_RST), 55);
    drain();

    for (int ph = 1; ph < TIMINGS; ph++) begin
      count    = 70;
      tick_pct = 55;
      case (ph)
        // step written with its unused upper bits set
        1: begin px = 9'h1FF; len = 9'd64;  frames = 9'd2;   end
        2: begin px = 9'd1;   len = 9'd511; frames = 9'd511; end
        // zero step after a long line: counter may sit above the new length
        3: begin px = 9'd0;   len = 9'd40;  frames = 9'd5;   end
        // zero length wraps mod 1024, zero frames pins the line at 0
        4: begin px = 9'd63;  len = 9'd0;   frames = 9'd0;   end
        // nearly a line per tick, long enough to pass line 255
        5: begin
          px = 9'd63; len = 9'd64; frames = 9'd511;
          count = 330; tick_pct = 92;
        end
        6: begin px = 9'd37;  len = 9'd100; frames = 9'd1;   end
        default: begin
          px     = 9'($urandom_range(0, 63));
          len    = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(64, 200));
          frames = 9'($urandom_range(2, 40));
          count  = 50;
        end
      endcase
      apply_setting(px, len, frames, ph == 1);
      run_random(count, 32'(frames), tick_pct);
      drain();
    end

    $display("covered %0d accesses over %0d pixel/line/frame settings", items_in, TIMINGS);
    $display("%0d raster interrupts seen, %0d result mismatches", irqs_seen, fail_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
